[rtl/itmm_pkg.sv]
// Package for the interval timer with minimum and maximum tracking.
// Holds the item and result payload types, the event codes and the timing constants.
// No dependencies.
`default_nettype none

package itmm_pkg;

    localparam int STAMP_W        = 20;
    localparam int OUT_CNT_W      = 32;
    localparam int STAMP_PERIOD   = 1000000;
    localparam int COUNT_BITS_DEF = 32;

    // Only the low bits of the period matter, because the interval is cut to STAMP_W bits.
    localparam logic [STAMP_W-1:0] PERIOD_LOW = STAMP_W'(STAMP_PERIOD);

    typedef enum logic [1:0] {
        EV_STARTED  = 2'd0,
        EV_RESTART  = 2'd1,
        EV_RESTOP   = 2'd2,
        EV_MEASURED = 2'd3
    } t_event;

    typedef struct packed {
        logic               command;
        logic               clear_stats;
        logic [STAMP_W-1:0] now_us;
    } t_item;

    typedef struct packed {
        t_event               event_kind;
        logic [STAMP_W-1:0]   interval_us;
        logic [STAMP_W-1:0]   min_us;
        logic [STAMP_W-1:0]   max_us;
        logic [OUT_CNT_W-1:0] restart_count;
        logic [OUT_CNT_W-1:0] restop_count;
        logic [STAMP_W-1:0]   stamp_echo;
    } t_result;

endpackage

`default_nettype wire

[rtl/itmm_if.sv]
// Valid/ready stream interfaces for the interval timer items and results.
// Depends on itmm_pkg for the payload types.
`default_nettype none

interface itmm_item_if;
    import itmm_pkg::*;

    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface itmm_result_if;
    import itmm_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/itmm_event.sv]
// Timer state and per-item event logic: start stamp, interval, min/max and counters.
// Produces the next result combinationally and updates the state when an item advances.
// Depends on itmm_pkg.
`default_nettype none

module itmm_event #(
    parameter int COUNT_BITS = itmm_pkg::COUNT_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_fire,
    input  wire itmm_pkg::t_item i_item,
    output itmm_pkg::t_result    o_result
);
    import itmm_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  r_running,   n_running;
    logic [STAMP_W-1:0]    r_start,     n_start;
    logic                  r_reseed,    n_reseed;
    logic [STAMP_W-1:0]    r_interval,  n_interval;
    logic [STAMP_W-1:0]    r_min,       n_min;
    logic [STAMP_W-1:0]    r_max,       n_max;
    logic [COUNT_BITS-1:0] r_restarts,  n_restarts;
    logic [COUNT_BITS-1:0] r_restops,   n_restops;

    t_event             kind;
    logic [STAMP_W-1:0] elapsed;
    logic               reseed_now;

    // A single wrap through the period; longer intervals alias.
    always_comb begin
        if (i_item.now_us >= r_start) begin
            elapsed = i_item.now_us - r_start;
        end else begin
            elapsed = PERIOD_LOW - r_start + i_item.now_us;
        end
    end

    always_comb begin
        reseed_now = r_reseed | i_item.clear_stats;
        n_running  = r_running;
        n_start    = r_start;
        n_reseed   = reseed_now;
        n_interval = r_interval;
        n_min      = r_min;
        n_max      = r_max;
        n_restarts = r_restarts;
        n_restops  = r_restops;

        priority if (i_item.command && !r_running) begin
            kind      = EV_STARTED;
            n_start   = i_item.now_us;
            n_running = 1'b1;
        end else if (i_item.command) begin
            kind = EV_RESTART;
            if (r_restarts != CNT_MAX) begin
                n_restarts = r_restarts + 1'b1;
            end
        end else if (!r_running) begin
            kind = EV_RESTOP;
            if (r_restops != CNT_MAX) begin
                n_restops = r_restops + 1'b1;
            end
        end else begin
            kind       = EV_MEASURED;
            n_running  = 1'b0;
            n_interval = elapsed;
            if (reseed_now) begin
                n_min      = elapsed;
                n_max      = elapsed;
                n_restarts = '0;
                n_restops  = '0;
                n_reseed   = 1'b0;
            end else begin
                if (elapsed > r_max) begin
                    n_max = elapsed;
                end
                if (elapsed < r_min) begin
                    n_min = elapsed;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_start    <= '0;
            r_reseed   <= 1'b1;
            r_interval <= '0;
            r_min      <= '0;
            r_max      <= '0;
            r_restarts <= '0;
            r_restops  <= '0;
        end else if (i_fire) begin
            r_running  <= n_running;
            r_start    <= n_start;
            r_reseed   <= n_reseed;
            r_interval <= n_interval;
            r_min      <= n_min;
            r_max      <= n_max;
            r_restarts <= n_restarts;
            r_restops  <= n_restops;
        end
    end

    always_comb begin
        o_result.event_kind    = kind;
        o_result.interval_us   = n_interval;
        o_result.min_us        = n_min;
        o_result.max_us        = n_max;
        o_result.restart_count = OUT_CNT_W'(n_restarts);
        o_result.restop_count  = OUT_CNT_W'(n_restops);
        o_result.stamp_echo    = i_item.now_us;
    end

    a_stop_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && kind == EV_MEASURED |=> !r_running)
        else $error("timer still running after a measured interval");

    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && kind == EV_STARTED |=> r_running && r_start == $past(i_item.now_us))
        else $error("start did not latch the timestamp");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= r_max)
        else $error("minimum exceeds maximum");

    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && kind != EV_MEASURED |=>
            r_restarts >= $past(r_restarts) && r_restops >= $past(r_restops))
        else $error("counter decreased without a reseed");

    a_clear_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.clear_stats && kind != EV_MEASURED |=> r_reseed)
        else $error("clear request was lost");

endmodule

`default_nettype wire

[rtl/interval_timer_min_max.sv]
// Start/stop interval timer with running minimum, maximum and saturating counters.
// Each item is held in the input register, then its result is written to the result register.
// Throughput: one item per cycle while results are taken; one pass from input to result register.
// The input stage stalls only while the result register is full and not taken.
// Reset (synchronous, active low): idle, no start stamp, statistics zero, reseed pending.
`default_nettype none

module interval_timer_min_max #(
    parameter int COUNT_BITS = itmm_pkg::COUNT_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    itmm_item_if.sink      i_item,
    itmm_result_if.source  o_result
);
    import itmm_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result next_result;
    logic    advance;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
    end

    itmm_event #(
        .COUNT_BITS(COUNT_BITS)
    ) u_event (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (next_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

`default_nettype wire
